// ===== rtl/mrwr_pkg.sv =====
package mrwr_pkg;

  typedef enum logic [1:0] {
    REASON_PASS    = 2'd0,
    REASON_TRIVIAL = 2'd1,
    REASON_ROOT    = 2'd2,
    REASON_POWER   = 2'd3
  } reason_e;

endpackage

// ===== rtl/miller_rabin_witness_round.sv =====
// One Miller-Rabin round per request: candidate n and a raw witness go in on the slave
// stream, one verdict (probable_prime, reason) comes out on the master stream. The base is
// (witness mod (n-1)) + 1, reduced bit-serially. A single shift-add
// modular multiplier (one conditional add and one doubling per cycle) serves the
// exponentiation and the squarings; candidates below 2, even candidates and 2 itself are
// answered without any arithmetic. The block takes no request while busy.
module miller_rabin_witness_round #(
  parameter int NUM_BITS = 63
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [NUM_BITS-1:0] candidate, [2*NUM_BITS-1:NUM_BITS] witness, zero padding above
  input  logic [((2*NUM_BITS+7)/8)*8-1:0]         s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // [0] probable_prime, [2:1] reason, zero padding above
  output logic [7:0]                              m_axis_tdata
);

  localparam int W  = NUM_BITS;
  localparam int CW = $clog2(W + 2);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SPLIT, ST_REDUCE, ST_POW_CHK, ST_MUL, ST_POW_NEXT, ST_SQ_CHK, ST_SQ_NEXT,
    ST_DONE
  } state_e;

  state_e state_q;
  logic [W-1:0] n_q, w_q, rem_q, u_q, b_q, x_q, prev_q;
  logic [W-1:0] ma_q, mb_q, acc_q;
  logic [CW-1:0] cnt_q, k_q;
  logic sq_q;  // multiply target: 1 squares x, 0 is a pow step
  logic pmul_q; // pow step phase: 1 x*b, 0 b*b
  mrwr_pkg::reason_e reason_q;

  logic [W-1:0] n_in, w_in, nm1;
  logic [W:0] acc_sum, a_dbl, rem_sh;
  assign n_in = s_axis_tdata[W-1:0];
  assign w_in = s_axis_tdata[2*W-1:W];
  assign nm1  = n_q - W'(1);
  assign acc_sum = {1'b0, acc_q} + {1'b0, ma_q};
  assign a_dbl   = {ma_q, 1'b0};
  assign rem_sh  = {rem_q, w_q[W-1]};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_DONE);
  assign m_axis_tdata  = {5'd0, reason_q, reason_q == mrwr_pkg::REASON_PASS};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      reason_q <= mrwr_pkg::REASON_PASS;
    end else begin
      unique case (state_q)
        ST_IDLE: if (s_axis_tvalid) begin
          n_q <= n_in;
          w_q <= w_in;
          priority if (n_in < W'(2) || (!n_in[0] && n_in != W'(2))) begin
            reason_q <= mrwr_pkg::REASON_TRIVIAL;
            state_q  <= ST_DONE;
          end else if (n_in == W'(2)) begin
            reason_q <= mrwr_pkg::REASON_PASS;
            state_q  <= ST_DONE;
          end else begin
            u_q   <= n_in - W'(1);
            k_q   <= '0;
            state_q <= ST_SPLIT;
          end
        end
        ST_SPLIT: begin
          if (!u_q[0]) begin
            u_q <= u_q >> 1;
            k_q <= k_q + CW'(1);
          end else begin
            rem_q <= '0;
            cnt_q <= CW'(W);
            state_q <= ST_REDUCE;
          end
        end
        // restoring remainder, one witness bit a cycle
        ST_REDUCE: begin
          if (cnt_q == '0) begin
            b_q <= rem_q + W'(1);
            x_q <= W'(1);
            state_q <= ST_POW_CHK;
          end else begin
            rem_q <= (rem_sh >= {1'b0, nm1}) ? W'(rem_sh - {1'b0, nm1}) : W'(rem_sh);
            w_q <= w_q << 1;
            cnt_q <= cnt_q - CW'(1);
          end
        end
        ST_POW_CHK: begin
          if (u_q == '0) begin
            prev_q <= x_q;
            cnt_q  <= k_q;
            state_q <= ST_SQ_CHK;
          end else if (u_q[0]) begin
            ma_q <= x_q; mb_q <= b_q; acc_q <= '0;
            sq_q <= 1'b0; pmul_q <= 1'b1; state_q <= ST_MUL;
          end else begin
            ma_q <= b_q; mb_q <= b_q; acc_q <= '0;
            sq_q <= 1'b0; pmul_q <= 1'b0; state_q <= ST_MUL;
          end
        end
        // shared shift-add modular multiplier
        ST_MUL: begin
          if (mb_q == '0) begin
            state_q <= sq_q ? ST_SQ_NEXT : ST_POW_NEXT;
          end else begin
            if (mb_q[0])
              acc_q <= (acc_sum >= {1'b0, n_q}) ? W'(acc_sum - {1'b0, n_q}) : W'(acc_sum);
            ma_q <= (a_dbl >= {1'b0, n_q}) ? W'(a_dbl - {1'b0, n_q}) : W'(a_dbl);
            mb_q <= mb_q >> 1;
          end
        end
        ST_POW_NEXT: begin
          if (pmul_q) begin
            x_q <= acc_q;
            ma_q <= b_q; mb_q <= b_q; acc_q <= '0;
            pmul_q <= 1'b0; state_q <= ST_MUL;
          end else begin
            b_q <= acc_q;
            u_q <= u_q >> 1;
            state_q <= ST_POW_CHK;
          end
        end
        ST_SQ_CHK: begin
          if (cnt_q == '0) begin
            reason_q <= (x_q != W'(1)) ? mrwr_pkg::REASON_POWER : mrwr_pkg::REASON_PASS;
            state_q  <= ST_DONE;
          end else begin
            ma_q <= x_q; mb_q <= x_q; acc_q <= '0;
            sq_q <= 1'b1; state_q <= ST_MUL;
          end
        end
        ST_SQ_NEXT: begin
          if (acc_q == W'(1) && prev_q != W'(1) && prev_q != nm1) begin
            reason_q <= mrwr_pkg::REASON_ROOT;
            state_q  <= ST_DONE;
          end else begin
            x_q <= acc_q;
            prev_q <= acc_q;
            cnt_q <= cnt_q - CW'(1);
            state_q <= ST_SQ_CHK;
          end
        end
        ST_DONE: if (m_axis_tready) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
  a_mul_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> acc_q < n_q && ma_q < n_q)
    else $error("multiplier operand out of range");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("ready while result pending");

endmodule
